/* rtl/core/cle_pkg.sv */
// cle_pkg: shared types and constants for the circular list engine.
// Used by cle_store, cle_alloc, cle_ctrl and circular_list_engine.
package cle_pkg;

   localparam int CLE_CAPACITY = 16;
   localparam int CLE_VALUE_W  = 32;

   typedef enum logic [1:0] {
      CMD_INS_FRONT = 2'd0,
      CMD_INS_BACK  = 2'd1,
      CMD_DELETE    = 2'd2,
      CMD_DUMP      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_INS_LINK,
      S_INS_TAIL,
      S_WALK_HEAD,
      S_DEL_CMP,
      S_DUMP
   } state_type;

endpackage

/* rtl/core/circular_list_engine.sv */
// circular_list_engine: top level of the circular linked list engine.
// Instantiates cle_ctrl, cle_store and cle_alloc; depends on cle_pkg.
//
// Usage:
//   A command word (req_command, req_data_value) is taken when start is high
//   and busy is low. Commands: insert front, insert back, delete first equal
//   value, dump. Each result word is on the rsp_ ports for one cycle with
//   rsp_strobe high; rsp_last_of_run marks the final word of a command.
//   The receiver cannot stall the block; words come whether taken or not.
// States walked after a command is taken; the result word is then registered:
//   insert into an empty list, full or empty-list status: S_DECODE.
//   insert into a non-empty list: S_DECODE, S_INS_LINK, S_INS_TAIL.
//   delete: S_DECODE, S_WALK_HEAD, then S_DEL_CMP for each entry compared.
//   dump: S_DECODE, S_WALK_HEAD, then S_DUMP gives one word per cycle.
// Throughput is one list entry per cycle, set by the single shared read port
// of the value and link memories; busy drops in the cycle of the last word,
// so the next command can be taken then.
// Reset (synchronous) empties the list: occupancy, count and tail are
// cleared; memory contents are left as they are.
module circular_list_engine #(
   parameter int CAPACITY = cle_pkg::CLE_CAPACITY
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [1:0]                              req_command,
   input  logic signed [cle_pkg::CLE_VALUE_W-1:0]  req_data_value,
   output logic                                    rsp_strobe,
   output logic [1:0]                              rsp_status,
   output logic signed [cle_pkg::CLE_VALUE_W-1:0]  rsp_entry_value,
   output logic                                    rsp_last_of_run
);
   import cle_pkg::*;

   localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic                   val_we;
   logic [SW-1:0]          val_waddr;
   logic [CLE_VALUE_W-1:0] val_wdata;
   logic                   link_we;
   logic [SW-1:0]          link_waddr;
   logic [SW-1:0]          link_wdata;
   logic [SW-1:0]          raddr;
   logic [CLE_VALUE_W-1:0] val_rdata;
   logic [SW-1:0]          link_rdata;
   logic                   use_set;
   logic                   use_clr;
   logic [SW-1:0]          use_slot;
   logic [SW-1:0]          free_slot;
   logic [CLE_VALUE_W-1:0] entry_value;

   cle_ctrl #(
      .CAPACITY (CAPACITY),
      .SW       (SW),
      .CW       (CW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .cmd             (req_command),
      .data_value      (req_data_value),
      .val_we          (val_we),
      .val_waddr       (val_waddr),
      .val_wdata       (val_wdata),
      .link_we         (link_we),
      .link_waddr      (link_waddr),
      .link_wdata      (link_wdata),
      .raddr           (raddr),
      .val_rdata       (val_rdata),
      .link_rdata      (link_rdata),
      .use_set         (use_set),
      .use_clr         (use_clr),
      .use_slot        (use_slot),
      .free_slot       (free_slot),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_entry_value (entry_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

   cle_store #(
      .CAPACITY (CAPACITY),
      .SW       (SW)
   ) u_store (
      .clock      (clock),
      .val_we     (val_we),
      .val_waddr  (val_waddr),
      .val_wdata  (val_wdata),
      .link_we    (link_we),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .raddr      (raddr),
      .val_rdata  (val_rdata),
      .link_rdata (link_rdata)
   );

   cle_alloc #(
      .CAPACITY (CAPACITY),
      .SW       (SW)
   ) u_alloc (
      .clock     (clock),
      .reset     (reset),
      .set_en    (use_set),
      .clr_en    (use_clr),
      .slot      (use_slot),
      .free_slot (free_slot)
   );

   assign rsp_entry_value = entry_value;

endmodule

/* rtl/core/cle_store.sv */
// cle_store: value and link memories, one write port each, shared read address.
// Read data is registered. Depends on cle_pkg.
module cle_store #(
   parameter int CAPACITY = cle_pkg::CLE_CAPACITY,
   parameter int SW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                               clock,
   input  logic                               val_we,
   input  logic [SW-1:0]                      val_waddr,
   input  logic [cle_pkg::CLE_VALUE_W-1:0]    val_wdata,
   input  logic                               link_we,
   input  logic [SW-1:0]                      link_waddr,
   input  logic [SW-1:0]                      link_wdata,
   input  logic [SW-1:0]                      raddr,
   output logic [cle_pkg::CLE_VALUE_W-1:0]    val_rdata,
   output logic [SW-1:0]                      link_rdata
);
   import cle_pkg::*;

   logic [CLE_VALUE_W-1:0] val_mem  [CAPACITY];
   logic [SW-1:0]          link_mem [CAPACITY];
   logic [CLE_VALUE_W-1:0] val_rdata_ff;
   logic [SW-1:0]          link_rdata_ff;

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      val_rdata_ff <= val_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rdata_ff <= link_mem[raddr];
   end

   assign val_rdata  = val_rdata_ff;
   assign link_rdata = link_rdata_ff;

endmodule

/* rtl/core/cle_alloc.sv */
// cle_alloc: slot occupancy bits and registered lowest-free-slot finder.
// Depends on cle_pkg.
module cle_alloc #(
   parameter int CAPACITY = cle_pkg::CLE_CAPACITY,
   parameter int SW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          set_en,
   input  logic          clr_en,
   input  logic [SW-1:0] slot,
   output logic [SW-1:0] free_slot
);
   import cle_pkg::*;

   logic [CAPACITY-1:0] in_use_ff;
   logic [CAPACITY-1:0] in_use_in;
   logic [SW-1:0]       free_ff;
   logic [SW-1:0]       free_in;

   always_comb begin
      in_use_in = in_use_ff;
      if (set_en) begin
         in_use_in[slot] = 1'b1;
      end else if (clr_en) begin
         in_use_in[slot] = 1'b0;
      end
   end

   always_comb begin
      free_in = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_in = SW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         free_ff   <= '0;
      end else begin
         in_use_ff <= in_use_in;
         free_ff   <= free_in;
      end
   end

   assign free_slot = free_ff;

endmodule

/* rtl/core/cle_ctrl.sv */
// cle_ctrl: command sequencer; walks the list through the store's read port.
// Holds tail slot, entry count and the result word registers. Depends on cle_pkg.
module cle_ctrl #(
   parameter int CAPACITY = cle_pkg::CLE_CAPACITY,
   parameter int SW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       cmd,
   input  logic [cle_pkg::CLE_VALUE_W-1:0]  data_value,
   output logic                             val_we,
   output logic [SW-1:0]                    val_waddr,
   output logic [cle_pkg::CLE_VALUE_W-1:0]  val_wdata,
   output logic                             link_we,
   output logic [SW-1:0]                    link_waddr,
   output logic [SW-1:0]                    link_wdata,
   output logic [SW-1:0]                    raddr,
   input  logic [cle_pkg::CLE_VALUE_W-1:0]  val_rdata,
   input  logic [SW-1:0]                    link_rdata,
   output logic                             use_set,
   output logic                             use_clr,
   output logic [SW-1:0]                    use_slot,
   input  logic [SW-1:0]                    free_slot,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_status,
   output logic [cle_pkg::CLE_VALUE_W-1:0]  rsp_entry_value,
   output logic                             rsp_last_of_run
);
   import cle_pkg::*;

   state_type              state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [CLE_VALUE_W-1:0] val_ff, val_in;
   logic [SW-1:0]          tail_ff, tail_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [SW-1:0]          prev_ff, prev_in;
   logic [SW-1:0]          cur_ff, cur_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic                   strobe_ff, strobe_in;
   status_type             status_ff, status_in;
   logic [CLE_VALUE_W-1:0] entry_ff, entry_in;
   logic                   last_ff, last_in;
   logic                   at_end;

   assign at_end = (CW'(idx_ff + 1'b1) == count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         tail_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      val_ff    <= val_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      entry_ff  <= entry_in;
      last_ff   <= last_in;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      val_in     = val_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      prev_in    = prev_ff;
      cur_in     = cur_ff;
      idx_in     = idx_ff;
      strobe_in  = 1'b0;
      status_in  = ST_OK;
      entry_in   = '0;
      last_in    = 1'b1;
      val_we     = 1'b0;
      val_waddr  = free_slot;
      val_wdata  = val_ff;
      link_we    = 1'b0;
      link_waddr = free_slot;
      link_wdata = free_slot;
      raddr      = tail_ff;
      use_set    = 1'b0;
      use_clr    = 1'b0;
      use_slot   = free_slot;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = cmd_type'(cmd);
               val_in   = data_value;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            prev_in = tail_ff;
            unique case (cmd_ff)
               CMD_INS_FRONT, CMD_INS_BACK: begin
                  if (count_ff == CW'(CAPACITY)) begin
                     strobe_in = 1'b1;
                     status_in = ST_FULL;
                     state_in  = S_IDLE;
                  end else if (count_ff == '0) begin
                     val_we    = 1'b1;
                     link_we   = 1'b1;
                     use_set   = 1'b1;
                     tail_in   = free_slot;
                     count_in  = CW'(count_ff + 1'b1);
                     strobe_in = 1'b1;
                     state_in  = S_IDLE;
                  end else begin
                     state_in = S_INS_LINK;
                  end
               end
               CMD_DELETE, CMD_DUMP: begin
                  if (count_ff == '0) begin
                     strobe_in = 1'b1;
                     status_in = ST_EMPTY;
                     state_in  = S_IDLE;
                  end else begin
                     state_in = S_WALK_HEAD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         // new entry links to the current front
         S_INS_LINK: begin
            val_we     = 1'b1;
            link_we    = 1'b1;
            link_wdata = link_rdata;
            state_in   = S_INS_TAIL;
         end

         S_INS_TAIL: begin
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = free_slot;
            use_set    = 1'b1;
            if (cmd_ff == CMD_INS_BACK) begin
               tail_in = free_slot;
            end
            count_in  = CW'(count_ff + 1'b1);
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end

         S_WALK_HEAD: begin
            raddr  = link_rdata;
            cur_in = link_rdata;
            idx_in = '0;
            if (cmd_ff == CMD_DUMP) begin
               state_in = S_DUMP;
            end else begin
               state_in = S_DEL_CMP;
            end
         end

         S_DEL_CMP: begin
            raddr = link_rdata;
            if (val_rdata == val_ff) begin
               use_clr  = 1'b1;
               use_slot = cur_ff;
               if (count_ff == CW'(1)) begin
                  count_in = '0;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff;
                  link_wdata = link_rdata;
                  if (cur_ff == tail_ff) begin
                     tail_in = prev_ff;
                  end
                  count_in = CW'(count_ff - 1'b1);
               end
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end else if (at_end) begin
               strobe_in = 1'b1;
               status_in = ST_NOT_FOUND;
               state_in  = S_IDLE;
            end else begin
               prev_in = cur_ff;
               cur_in  = link_rdata;
               idx_in  = CW'(idx_ff + 1'b1);
            end
         end

         S_DUMP: begin
            raddr     = link_rdata;
            strobe_in = 1'b1;
            entry_in  = val_rdata;
            last_in   = at_end;
            idx_in    = CW'(idx_ff + 1'b1);
            if (at_end) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_value = entry_ff;
   assign rsp_last_of_run = last_ff;

endmodule

/* bench/circular_list_engine_tb.sv */
`timescale 1ns / 100ps
// circular_list_engine_tb: self-checking bench for the circular list engine.
// Needs cle_pkg and circular_list_engine; predicts every result word in-bench.
module circular_list_engine_tb;
   import cle_pkg::*;

   localparam int CAP        = CLE_CAPACITY;
   localparam int SLOT_W     = $clog2(CAP);
   localparam int RAND_ITEMS = 230;
   localparam int QUIET_MAX  = 4000;

   typedef struct {
      cmd_type                  cmd;
      logic signed [31:0]       value;
      int                       gap;
      bit                       drain;
   } list_cmd_type;

   typedef struct {
      status_type               status;
      logic signed [31:0]       value;
      logic                     last;
   } list_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [1:0]                  req_command = CMD_DUMP;
   logic signed [31:0]          req_data_value = '0;
   logic                        rsp_strobe;
   logic [1:0]                  rsp_status;
   logic signed [31:0]          rsp_entry_value;
   logic                        rsp_last_of_run;

   list_cmd_type                cmd_backlog[$];
   list_word_type               expected_words[$];
   logic signed [31:0]          recent_values[$];
   int                          errors = 0;

   // shadow copy of the list
   logic signed [31:0]          shadow_val [CAP];
   logic [SLOT_W-1:0]           shadow_next[CAP];
   logic [CAP-1:0]              shadow_used = '0;
   logic [SLOT_W-1:0]           shadow_tail = '0;
   int                          shadow_count = 0;

   circular_list_engine DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_data_value  (req_data_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #4 clock = ~clock;

   function automatic void push_word(status_type st, logic signed [31:0] v, logic lst);
      list_word_type w;
      w.status = st;
      w.value  = v;
      w.last   = lst;
      expected_words.push_back(w);
   endfunction

   function automatic void apply_list_command(cmd_type cmd, logic signed [31:0] v);
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] prev;
      logic [SLOT_W-1:0] cur;
      bit                hit;
      int                i;
      hit  = 1'b0;
      slot = '0;
      case (cmd)
         CMD_INS_FRONT, CMD_INS_BACK: begin
            if (shadow_count >= CAP) begin
               push_word(ST_FULL, 32'sd0, 1'b1);
            end else begin
               for (i = 0; i < CAP; i++) begin
                  if (!hit && !shadow_used[i]) begin
                     slot = SLOT_W'(i);
                     hit  = 1'b1;
                  end
               end
               shadow_val[slot] = v;
               if (shadow_count == 0) begin
                  shadow_next[slot] = slot;
                  shadow_tail       = slot;
               end else begin
                  shadow_next[slot]        = shadow_next[shadow_tail];
                  shadow_next[shadow_tail] = slot;
                  if (cmd == CMD_INS_BACK) shadow_tail = slot;
               end
               shadow_used[slot] = 1'b1;
               shadow_count++;
               push_word(ST_OK, 32'sd0, 1'b1);
            end
         end
         CMD_DELETE: begin
            if (shadow_count == 0) begin
               push_word(ST_EMPTY, 32'sd0, 1'b1);
            end else begin
               prev = shadow_tail;
               cur  = shadow_next[prev];
               for (i = 0; i < shadow_count && !hit; i++) begin
                  if (shadow_val[cur] == v) begin
                     hit = 1'b1;
                  end else begin
                     prev = cur;
                     cur  = shadow_next[cur];
                  end
               end
               if (hit) begin
                  if (shadow_count == 1) begin
                     shadow_count = 0;
                  end else begin
                     shadow_next[prev] = shadow_next[cur];
                     if (cur == shadow_tail) shadow_tail = prev;
                     shadow_count--;
                  end
                  shadow_used[cur] = 1'b0;
                  push_word(ST_OK, 32'sd0, 1'b1);
               end else begin
                  push_word(ST_NOT_FOUND, 32'sd0, 1'b1);
               end
            end
         end
         default: begin
            if (shadow_count == 0) begin
               push_word(ST_EMPTY, 32'sd0, 1'b1);
            end else begin
               cur = shadow_next[shadow_tail];
               for (i = 0; i < shadow_count; i++) begin
                  push_word(ST_OK, shadow_val[cur], (i == shadow_count - 1));
                  cur = shadow_next[cur];
               end
            end
         end
      endcase
   endfunction

   // driver
   always @(posedge clock) begin : drive_proc
      bit         took;
      static list_cmd_type cur_word;
      static int  gap_left = 0;
      if (reset) begin
         start    <= 1'b0;
         gap_left = 0;
      end else begin
         took = start && !busy;
         if (took) begin
            apply_list_command(cur_word.cmd, cur_word.value);
            gap_left = cur_word.gap;
         end
         if (start && !took) begin
            // hold the word until taken
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (cmd_backlog.size() > 0 && cmd_backlog[0].drain) begin
            if (expected_words.size() == 0 && !rsp_strobe) cmd_backlog.delete(0);
            start <= 1'b0;
         end else if (cmd_backlog.size() > 0) begin
            cur_word       = cmd_backlog.pop_front();
            start          <= 1'b1;
            req_command    <= cur_word.cmd;
            req_data_value <= cur_word.value;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_proc
      list_word_type want;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word status=%0d value=%0d last=%0b", $time,
                     rsp_status, rsp_entry_value, rsp_last_of_run);
            errors++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_status !== want.status || rsp_entry_value !== want.value ||
                rsp_last_of_run !== want.last) begin
               $display("%0t: exp st=%0d val=%0d last=%0b, got st=%0d val=%0d last=%0b",
                        $time, want.status, want.value, want.last,
                        rsp_status, rsp_entry_value, rsp_last_of_run);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog_proc
      static int quiet = 0;
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_MAX) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic int pick_gap(bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return $signed($urandom_range(0, 7)) - 3;
      if (r == 4) begin
         case ($urandom_range(0, 3))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic add_word(cmd_type cmd, logic signed [31:0] v, int gap);
      list_cmd_type c;
      c.cmd   = cmd;
      c.value = v;
      c.gap   = gap;
      c.drain = 1'b0;
      cmd_backlog.push_back(c);
   endtask

   task automatic add_drain();
      list_cmd_type c;
      c.cmd   = CMD_DUMP;
      c.value = '0;
      c.gap   = 0;
      c.drain = 1'b1;
      cmd_backlog.push_back(c);
   endtask

   task automatic add_insert(bit burst);
      logic signed [31:0] v;
      v = pick_value();
      recent_values.push_back(v);
      if (recent_values.size() > 40) v = recent_values.pop_front();
      add_word($urandom_range(0, 1) ? CMD_INS_BACK : CMD_INS_FRONT, recent_values[$],
               pick_gap(burst));
   endtask

   task automatic add_delete(bit burst);
      logic signed [31:0] v;
      int                 idx;
      if (recent_values.size() > 0 && $urandom_range(0, 3) != 0) begin
         idx = $urandom_range(0, recent_values.size() - 1);
         v   = recent_values[idx];
         recent_values.delete(idx);
      end else begin
         v = pick_value();
      end
      add_word(CMD_DELETE, v, pick_gap(burst));
   endtask

   initial begin : stim_proc
      int  rand_count;
      int  kind;
      int  len;
      int  r;
      int  i;
      bit  burst;

      // directed: empty list, lone entry removed, extremes, absent value, tail and front
      add_word(CMD_DUMP,      32'sd0,           pick_gap(0));
      add_word(CMD_DELETE,    32'sd5,           pick_gap(0));
      add_word(CMD_INS_FRONT, 32'sh7FFF_FFFF,   pick_gap(0));
      add_word(CMD_DELETE,    32'sh7FFF_FFFF,   pick_gap(0));
      add_word(CMD_DUMP,      -32'sd1,          pick_gap(0));
      add_word(CMD_INS_BACK,  32'sh8000_0000,   pick_gap(0));
      add_word(CMD_INS_FRONT, -32'sd1,          pick_gap(0));
      add_word(CMD_INS_BACK,  32'sd0,           pick_gap(0));
      add_word(CMD_INS_FRONT, 32'sd1,           pick_gap(0));
      add_word(CMD_DUMP,      32'sh5555_AAAA,   pick_gap(0));
      add_word(CMD_DELETE,    32'sd12345,       pick_gap(0));
      add_word(CMD_DELETE,    32'sd0,           pick_gap(0));
      add_word(CMD_DELETE,    32'sd1,           pick_gap(0));
      add_word(CMD_DUMP,      32'shAAAA_5555,   pick_gap(0));
      recent_values.push_back(-32'sd1);
      recent_values.push_back(32'sh8000_0000);

      // fill to capacity and past it, then hold off until idle
      rand_count = cmd_backlog.size();
      for (i = 0; i < 16; i++) begin
         add_insert(1'b0);
         rand_count++;
      end
      add_word(CMD_DUMP, $urandom, pick_gap(0));
      add_drain();
      rand_count++;

      while (rand_count < RAND_ITEMS) begin
         kind  = $urandom_range(0, 2);
         len   = $urandom_range(8, 30);
         burst = ($urandom_range(0, 3) == 0);
         for (i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            case (kind)
               0:       r = (r < 75) ? 0 : (r < 90) ? 1 : 2;
               1:       r = (r < 15) ? 0 : (r < 90) ? 1 : 2;
               default: r = (r < 40) ? 0 : (r < 80) ? 1 : 2;
            endcase
            if (r == 0) add_insert(burst);
            else if (r == 1) add_delete(burst);
            else add_word(CMD_DUMP, $urandom, pick_gap(burst));
            rand_count++;
         end
         add_word(CMD_DUMP, $urandom, pick_gap(burst));
         rand_count++;
         if ($urandom_range(0, 1) == 0) add_drain();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (cmd_backlog.size() != 0 || start || expected_words.size() != 0);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
